// File: hdl/tilt_angle_window_detector_top_macros.svh
// Assertion macros for the tilt angle window detector.
// Used by files that check their own logic; expects clk and rst_n in scope.
`ifndef TILT_ANGLE_WINDOW_DETECTOR_TOP_MACROS_SVH
`define TILT_ANGLE_WINDOW_DETECTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TAWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TAWD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TAWD_ASSERT(lbl, prop, msg)
`define TAWD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/tawd_pkg.sv
// Shared constants, types and the arctangent table of the tilt detector.
// No dependencies.
`timescale 1ns / 1ps
package tawd_pkg;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int ZFRAC = 20;
  localparam int MAX_STEPS = 24;

  localparam int RAW_W = 9 + ANGLE_FRAC_BITS;
  localparam int CMP_W = (RAW_W + 1 > 16) ? RAW_W + 1 : 17;
  localparam int STEP_W = 5;
  localparam int XY_W = 27;
  localparam int Z_W = 30;
  localparam int ROOT_W = 24;
  localparam int RAD_W = 48;
  localparam int SUM_W = 32;

  typedef logic signed [RAW_W-1:0] raw_t;

  localparam raw_t OFFSET_RESET = raw_t'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam raw_t ANGLE_TOP = raw_t'(180 * (2 ** ANGLE_FRAC_BITS));

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_LEVEL = 2'd1;
  localparam logic [1:0] EV_TILT = 2'd2;

  localparam logic [1:0] REG_X_LOW = 2'd0;
  localparam logic [1:0] REG_X_HIGH = 2'd1;
  localparam logic [1:0] REG_Y_LOW = 2'd2;
  localparam logic [1:0] REG_Y_HIGH = 2'd3;

  // atan(2^-i) in 1/2^20 degree
  function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0: v = 30'sd47185920;
      5'd1: v = 30'sd27855475;
      5'd2: v = 30'sd14718068;
      5'd3: v = 30'sd7471121;
      5'd4: v = 30'sd3750058;
      5'd5: v = 30'sd1876857;
      5'd6: v = 30'sd938658;
      5'd7: v = 30'sd469357;
      5'd8: v = 30'sd234682;
      5'd9: v = 30'sd117342;
      5'd10: v = 30'sd58671;
      5'd11: v = 30'sd29335;
      5'd12: v = 30'sd14668;
      5'd13: v = 30'sd7334;
      5'd14: v = 30'sd3667;
      5'd15: v = 30'sd1833;
      5'd16: v = 30'sd917;
      5'd17: v = 30'sd458;
      5'd18: v = 30'sd229;
      5'd19: v = 30'sd115;
      5'd20: v = 30'sd57;
      5'd21: v = 30'sd29;
      5'd22: v = 30'sd14;
      5'd23: v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// File: hdl/tawd_ifs.sv
// Valid/ready channel interfaces for sample words and result words.
// Depends on nothing.
`timescale 1ns / 1ps
interface tawd_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source(output valid, mode, accel_x, accel_y, accel_z, input ready);
  modport sink(input valid, mode, accel_x, accel_y, accel_z, output ready);
endinterface

interface tawd_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] tilt_x;
  logic signed [15:0] tilt_y;
  logic vertical;
  logic [1:0] event_res;
  modport source(output valid, tilt_x, tilt_y, vertical, event_res, input ready);
  modport sink(input valid, tilt_x, tilt_y, vertical, event_res, output ready);
endinterface

// File: hdl/tawd_sqrt.sv
// Bit-serial square root: one root bit per cycle, two radicand bits shifted in.
// Depends on tawd_pkg.
`timescale 1ns / 1ps
module tawd_sqrt
  import tawd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);
  localparam logic [STEP_W-1:0] LAST = STEP_W'(ROOT_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ROOT_W+3:0] rem_sh, trial, diff;

  assign rem_sh = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = diff[ROOT_W+1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[ROOT_W+1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// File: hdl/tawd_cordic.sv
// Iterative CORDIC vectoring: atan2(mag, c) one rotation per cycle, then round.
// Depends on tawd_pkg.
`timescale 1ns / 1ps
module tawd_cordic
  import tawd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ROOT_W-1:0] mag,
  input  logic signed [15:0] axis_c,
  output logic              done,
  output raw_t              angle
);
  localparam logic [STEP_W-1:0] LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam int RSH = ZFRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] HALF = Z_W'(2 ** (RSH - 1));
  localparam logic signed [Z_W-1:0] Z_START = Z_W'(90 * (2 ** ZFRAC));

  logic                   run_r, run_nxt;
  logic                   fin_r, fin_nxt;
  logic                   zero_r, zero_nxt;
  logic                   done_r, done_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [Z_W-1:0]  z_r, z_nxt, zrnd, zsh, tab;
  raw_t                   ang_r, ang_nxt;

  assign dx   = y_r >>> step_r;
  assign dy   = x_r >>> step_r;
  assign tab  = atan_step(step_r);
  assign zrnd = z_r + HALF;
  assign zsh  = zrnd >>> RSH;

  always_comb begin
    run_nxt  = run_r;
    fin_nxt  = 1'b0;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    ang_nxt  = ang_r;
    if (start) begin
      x_nxt    = XY_W'($signed({1'b0, mag}));
      y_nxt    = -XY_W'($signed({axis_c, 8'h00}));
      z_nxt    = Z_START;
      step_nxt = '0;
      zero_nxt = (mag == '0) && (axis_c == '0);
      run_nxt  = !((mag == '0) && (axis_c == '0));
      fin_nxt  = (mag == '0) && (axis_c == '0);
    end else if (run_r) begin
      if (!y_r[XY_W-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + tab;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - tab;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LAST) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end else if (fin_r) begin
      // round half up, clamp to 0..180 degrees
      if (zero_r || zsh < 0) begin
        ang_nxt = '0;
      end else if (zsh > Z_W'(ANGLE_TOP)) begin
        ang_nxt = ANGLE_TOP;
      end else begin
        ang_nxt = zsh[RAW_W-1:0];
      end
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    zero_r <= zero_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    ang_r  <= ang_nxt;
  end

  assign done  = done_r;
  assign angle = ang_r;
endmodule

// File: hdl/tilt_angle_window_detector_top.sv
// Tilt angle window detector, top level.
// in_if takes one word per item: mode 0 is a sample (three accelerations),
// mode 1 calibrates the offsets from the last raw angles. out_if returns
// exactly one result word per item: both tilts, the vertical flag and a
// level/tilted event. The APB port (psel..prdata) holds the four window
// limits at byte addresses 0, 4, 8, 12; write only while the block is idle.
// in_if.ready is high only while no item is in work. A sample runs per axis:
// two squaring steps, the bit-serial square root (24 root bits and a handoff)
// and the CORDIC (16 rotations, rounding, handoff); a sample word occupies
// the block until its result is loaded into the output register. A calibrate
// word skips the arithmetic and goes straight to that load. The serial root
// and CORDIC set the rate. The result sits in an output register; a stalled
// receiver holds it and the block waits before loading the next one.
// Synchronous reset (rst_n low) restores the limits to +-10 degrees, offsets
// to 90 degrees, last raw angles to 0 and the flag to not vertical.
`timescale 1ns / 1ps
`include "tilt_angle_window_detector_top_macros.svh"
module tilt_angle_window_detector_top
  import tawd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tawd_in_if.sink     in_if,
  tawd_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQA  = 3'd1;
  localparam logic [2:0] ST_SQB  = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_CORD = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic        axis_r, axis_nxt;
  logic        cal_r, cal_nxt;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [15:0] lim_r [4];
  raw_t        off_x_r, off_y_r, last_x_r, last_y_r;
  logic        level_r;
  logic        ov_r;
  logic signed [15:0] otx_r, oty_r;
  logic        over_r;
  logic [1:0]  oev_r;

  logic signed [15:0] op_a, op_b, op_c;
  logic signed [31:0] prod;
  logic        sq_start, sq_done, cd_start, cd_done;
  logic [ROOT_W-1:0] root;
  raw_t        angle;
  logic        accept, load;
  logic signed [CMP_W-1:0] tx, ty;
  logic        now;
  logic        wr;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign load = (state_r == ST_FIN) && (!ov_r || out_if.ready);

  assign op_a = axis_r ? ax_r : ay_r;
  assign op_b = az_r;
  assign op_c = axis_r ? ay_r : ax_r;
  assign prod = (state_r == ST_SQA) ? op_a * op_a : op_b * op_b;

  assign sq_start = (state_r == ST_SQB);
  assign cd_start = (state_r == ST_ROOT) && sq_done;

  tawd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({sum_nxt, 16'h0000}),
    .done     (sq_done),
    .root     (root)
  );

  tawd_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cd_start),
    .mag    (root),
    .axis_c (op_c),
    .done   (cd_done),
    .angle  (angle)
  );

  assign tx = CMP_W'(last_x_r) - CMP_W'(off_x_r);
  assign ty = CMP_W'(last_y_r) - CMP_W'(off_y_r);
  assign now = (tx > CMP_W'(lim_r[REG_X_LOW])) && (tx < CMP_W'(lim_r[REG_X_HIGH])) &&
               (ty > CMP_W'(lim_r[REG_Y_LOW])) && (ty < CMP_W'(lim_r[REG_Y_HIGH]));

  function automatic logic signed [15:0] sat16(input logic signed [CMP_W-1:0] v);
    logic signed [15:0] r;
    if (v > CMP_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -CMP_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cal_nxt   = cal_r;
    sum_nxt   = sum_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          axis_nxt  = 1'b0;
          cal_nxt   = in_if.mode;
          state_nxt = in_if.mode ? ST_FIN : ST_SQA;
        end
      end
      ST_SQA: begin
        sum_nxt   = SUM_W'(unsigned'(prod));
        state_nxt = ST_SQB;
      end
      ST_SQB: begin
        sum_nxt   = sum_r + SUM_W'(unsigned'(prod));
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done) begin
          state_nxt = ST_CORD;
        end
      end
      ST_CORD: begin
        if (cd_done) begin
          axis_nxt  = 1'b1;
          state_nxt = axis_r ? ST_FIN : ST_SQA;
        end
      end
      ST_FIN: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = 32'(lim_r[paddr[3:2]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      axis_r   <= 1'b0;
      cal_r    <= 1'b0;
      lim_r[REG_X_LOW]  <= -16'sd640;
      lim_r[REG_X_HIGH] <= 16'sd640;
      lim_r[REG_Y_LOW]  <= -16'sd640;
      lim_r[REG_Y_HIGH] <= 16'sd640;
      off_x_r  <= OFFSET_RESET;
      off_y_r  <= OFFSET_RESET;
      last_x_r <= '0;
      last_y_r <= '0;
      level_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cal_r   <= cal_nxt;
      if (wr) begin
        lim_r[paddr[3:2]] <= pwdata[15:0];
      end
      if ((state_r == ST_CORD) && cd_done) begin
        if (axis_r) begin
          last_y_r <= angle;
        end else begin
          last_x_r <= angle;
        end
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
      if (load) begin
        if (cal_r) begin
          off_x_r <= last_x_r;
          off_y_r <= last_y_r;
        end else begin
          level_r <= now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (accept) begin
      ax_r <= in_if.accel_x;
      ay_r <= in_if.accel_y;
      az_r <= in_if.accel_z;
    end
    if (load) begin
      if (cal_r) begin
        otx_r  <= '0;
        oty_r  <= '0;
        over_r <= level_r;
        oev_r  <= EV_NONE;
      end else begin
        otx_r  <= sat16(tx);
        oty_r  <= sat16(ty);
        over_r <= now;
        // flag change raises an event
        oev_r  <= (now == level_r) ? EV_NONE : (now ? EV_LEVEL : EV_TILT);
      end
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.tilt_x    = otx_r;
  assign out_if.tilt_y    = oty_r;
  assign out_if.vertical  = over_r;
  assign out_if.event_res = oev_r;

  `TAWD_ASSERT(a_busy_after_accept, accept |=> (state_r != ST_IDLE), "accept did not start work")
  `TAWD_ASSERT_NEVER(a_event_code, ov_r && (oev_r == 2'd3), "undefined event code")
  `TAWD_ASSERT(a_level_event, (ov_r && (oev_r == EV_LEVEL)) |-> over_r, "level event without flag")
  `TAWD_ASSERT(a_tilt_event, (ov_r && (oev_r == EV_TILT)) |-> !over_r, "tilt event with flag")
  `TAWD_ASSERT_NEVER(a_root_state, sq_done && (state_r != ST_ROOT), "root done out of sequence")
endmodule

// File: dv/tb_top.sv
// Testbench for the tilt angle window detector: drives sample and calibrate
// words, predicts every result with a CORDIC model of its own and checks them.
// Depends on tawd_pkg, tawd_ifs and tilt_angle_window_detector_top.
`timescale 1ns / 1ps

class tilt_scoreboard;
  localparam int TAB [24] = '{47185920, 27855475, 14718068, 7471121, 3750058,
    1876857, 938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667,
    1833, 917, 458, 229, 115, 57, 29, 14, 7};

  typedef struct {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic vert;
    logic [1:0] ev;
  } tilt_word_t;

  longint lim_xl, lim_xh, lim_yl, lim_yh;
  longint off_x, off_y, raw_x, raw_y;
  bit level;
  tilt_word_t pending[$];
  int errors;

  function new();
    lim_xl = -640; lim_xh = 640; lim_yl = -640; lim_yh = 640;
    off_x = 90 << tawd_pkg::ANGLE_FRAC_BITS;
    off_y = off_x;
    raw_x = 0; raw_y = 0; level = 0; errors = 0;
  endfunction

  function void set_limit(int idx, logic signed [15:0] v);
    case (idx)
      tawd_pkg::REG_X_LOW: lim_xl = v;
      tawd_pkg::REG_X_HIGH: lim_xh = v;
      tawd_pkg::REG_Y_LOW: lim_yl = v;
      tawd_pkg::REG_Y_HIGH: lim_yh = v;
      default: ;
    endcase
  endfunction

  static function longint isqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // atan2(sqrt(a^2+b^2), c) in 1/64 degree, clamped to 0..180 degrees
  static function longint angle(longint a, longint b, longint c);
    longint x, y, z, dx, dy, r, top;
    int sh;
    sh = tawd_pkg::ZFRAC - tawd_pkg::ANGLE_FRAC_BITS;
    top = 180 << tawd_pkg::ANGLE_FRAC_BITS;
    x = isqrt((a * a + b * b) << 16);
    y = -(c * 256);
    z = 64'sd90 << tawd_pkg::ZFRAC;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < tawd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += TAB[i];
      end else begin
        x -= dx; y += dy; z -= TAB[i];
      end
    end
    r = (z + (64'sd1 << (sh - 1))) >>> sh;
    if (r < 0) r = 0;
    if (r > top) r = top;
    return r;
  endfunction

  static function logic signed [15:0] sat(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function void note_item(logic md, logic signed [15:0] ax, logic signed [15:0] ay,
                          logic signed [15:0] az);
    tilt_word_t w;
    longint tx, ty;
    bit now;
    w.ev = tawd_pkg::EV_NONE;
    if (md) begin
      off_x = raw_x; off_y = raw_y;
      w.tx = 0; w.ty = 0; w.vert = level;
    end else begin
      raw_x = angle(ay, az, ax);
      raw_y = angle(ax, az, ay);
      tx = raw_x - off_x;
      ty = raw_y - off_y;
      now = tx > lim_xl && tx < lim_xh && ty > lim_yl && ty < lim_yh;
      if (now != level) begin
        level = now;
        w.ev = now ? tawd_pkg::EV_LEVEL : tawd_pkg::EV_TILT;
      end
      w.tx = sat(tx); w.ty = sat(ty); w.vert = now;
    end
    pending.push_back(w);
  endfunction

  function void check_result(logic signed [15:0] tx, logic signed [15:0] ty,
                             logic vert, logic [1:0] ev);
    tilt_word_t w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word tx=%0d ty=%0d", $time, tx, ty);
      errors++;
      return;
    end
    w = pending.pop_front();
    if (tx !== w.tx) begin
      $display("%0t: tilt_x expected %0d actual %0d", $time, w.tx, tx); errors++;
    end
    if (ty !== w.ty) begin
      $display("%0t: tilt_y expected %0d actual %0d", $time, w.ty, ty); errors++;
    end
    if (vert !== w.vert) begin
      $display("%0t: vertical expected %0d actual %0d", $time, w.vert, vert); errors++;
    end
    if (ev !== w.ev) begin
      $display("%0t: event_res expected %0d actual %0d", $time, w.ev, ev); errors++;
    end
  endfunction
endclass

module tb_top;
  import tawd_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tawd_in_if in_if();
  tawd_out_if out_if();

  tilt_angle_window_detector_top dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tilt_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  longint cycles = 0;

  initial begin
    in_if.valid = 0;
    in_if.mode = 0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    out_if.ready = 0;
  end

  initial begin
    forever #4 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls plus long hold-offs counted here
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready)
      board.check_result(out_if.tilt_x, out_if.tilt_y, out_if.vertical, out_if.event_res);
    if (!rst_n) begin
      out_if.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays high from one accepted word to the next unless the sender idles
  task automatic send_word(logic md, logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid <= 1;
    in_if.mode <= md;
    in_if.accel_x <= ax;
    in_if.accel_y <= ay;
    in_if.accel_z <= az;
    do @(posedge clk); while (!in_if.ready);
    board.note_item(md, ax, ay, az);
  endtask

  task automatic wait_drained();
    in_if.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic signed [15:0] v);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= {{16{v[15]}}, v};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    board.set_limit(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_windows(logic signed [15:0] xl, logic signed [15:0] xh,
                             logic signed [15:0] yl, logic signed [15:0] yh);
    write_limit(REG_X_LOW, xl);
    write_limit(REG_X_HIGH, xh);
    write_limit(REG_Y_LOW, yl);
    write_limit(REG_Y_HIGH, yh);
  endtask

  // mostly gravity-like vectors near an axis, some tiny vectors, some full-range noise and some calibrate words
  task automatic random_word();
    int k;
    logic [15:0] ax, ay, az;
    k = $urandom_range(99);
    if (k < 8) begin
      send_word(1, 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (k < 60) begin
      ax = 16'($signed($urandom_range(1000)) - 500);
      ay = 16'($signed($urandom_range(1000)) - 500);
      az = 16'($signed($urandom_range(1000)) - 500);
      case ($urandom_range(2))
        0: ax = 16'($signed($urandom_range(32767)) - 16384) | 16'h4000;
        1: ay = 16'($signed($urandom_range(32767)) - 16384) | 16'h4000;
        default: az = 16'($signed($urandom_range(32767)) - 16384) | 16'h4000;
      endcase
      send_word(0, ax, ay, az);
    end else if (k < 70) begin
      send_word(0, 16'($urandom_range(3) - 1), 16'($urandom_range(3) - 1),
                16'($urandom_range(3) - 1));
    end else begin
      send_word(0, 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, zero vector, calibrate before and after samples
    send_word(1, 16'h1234, 16'h5678, 16'h9abc);
    send_word(0, 0, 0, 0);
    send_word(0, 0, 0, 16'h4000);
    send_word(0, 16'h7fff, 0, 0);
    send_word(0, 16'h8000, 0, 0);
    send_word(0, 0, 16'h7fff, 0);
    send_word(0, 0, 16'h8000, 0);
    send_word(0, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(0, 16'h8000, 16'h8000, 16'h8000);
    send_word(0, 16'hffff, 16'hffff, 16'hffff);
    send_word(0, 16'h0001, 16'h0001, 16'h0001);
    send_word(0, 16'h7fff, 16'h8000, 16'h5555);
    send_word(0, 16'haaaa, 16'h5555, 16'h8000);
    send_word(0, 16'h4000, 0, 16'h4000);
    send_word(1, 0, 0, 0);
    send_word(0, 16'h4000, 0, 16'h4000);
    send_word(0, 16'h4100, 16'h0100, 16'h4000);
    send_word(0, 0, 0, 16'h4000);
    send_word(1, 16'hffff, 16'hffff, 16'hffff);
    wait_drained();

    // reset-value windows, wide, extreme and asymmetric windows, inverted/empty windows
    set_windows(-23040, 23040, -23040, 23040);
    send_idle_pct = 38; recv_idle_pct = 63;
    repeat (100) random_word();
    wait_drained();

    set_windows(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    repeat (40) random_word();
    // long receiver hold-off while words keep coming
    hold_off <= 300;
    repeat (10) random_word();
    wait_drained();

    set_windows(640, -640, 0, 0);
    send_idle_pct = 63; recv_idle_pct = 38;
    repeat (60) random_word();
    wait_drained();

    set_windows(-1280, 1280, -320, 960);
    repeat (60) random_word();
    wait_drained();

    set_windows(-640, 640, -640, 640);
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (160) random_word();

    wait_drained();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: tilt_angle_window_detector_top.f
+incdir+hdl
hdl/tawd_pkg.sv
hdl/tawd_ifs.sv
hdl/tawd_sqrt.sv
hdl/tawd_cordic.sv
hdl/tilt_angle_window_detector_top.sv
dv/tb_top.sv
